>>> rtl/dps_pkg.sv
// Package: shared types, register indexes and constants of the dash pattern segmenter.
`timescale 1ns / 1ps
package dps_pkg;

    localparam int MAX_INTERVALS_DEF = 4;
    localparam int FRAC_BITS_DEF     = 8;

    localparam int LEN_W   = 32;
    localparam int IVL_W   = 24;
    localparam int PAT_W   = 27;
    localparam int EST_W   = 40;
    localparam int DIST_W  = 34;
    localparam int LIM_W   = 6;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 32;
    localparam int KCNT_W  = 7;

    localparam logic [KCNT_W-1:0] MAX_RESULTS = 7'd64;

    // Register indexes
    localparam logic [CIDX_W-1:0] REG_INTERVAL_COUNT = 3'd0;
    localparam logic [CIDX_W-1:0] REG_DASH_PHASE     = 3'd1;
    localparam logic [CIDX_W-1:0] REG_INTERVAL_A     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_INTERVAL_B     = 3'd3;
    localparam logic [CIDX_W-1:0] REG_INTERVAL_C     = 3'd4;
    localparam logic [CIDX_W-1:0] REG_INTERVAL_D     = 3'd5;
    localparam logic [CIDX_W-1:0] REG_DASH_LIMIT     = 3'd6;

    // Result status codes
    localparam logic [1:0] ST_SEGMENT = 2'd0;
    localparam logic [1:0] ST_ABORTED = 2'd1;
    localparam logic [1:0] ST_FILL    = 2'd2;

    typedef struct packed {
        logic [LEN_W-1:0] contour_length;
        logic             contour_closed;
        logic             path_first;
        logic             stroke;
    } in_word_t;

    typedef struct packed {
        logic [LEN_W-1:0] seg_start;
        logic [LEN_W-1:0] seg_stop;
        logic             move_first;
        logic [1:0]       status;
        logic             last;
    } out_word_t;

endpackage

>>> rtl/dps_div.sv
// Serial restoring divider: one quotient bit per cycle, shared by phase and estimate.
`timescale 1ns / 1ps
module dps_div
    import dps_pkg::*;
#(
    parameter int DW = 41
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DW-1:0]    dividend,
    input  logic [PAT_W-1:0] divisor,
    output logic             done,
    output logic [DW-1:0]    quotient,
    output logic [PAT_W-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic [DW-1:0]    quo_reg, quo_next;
    logic [PAT_W-1:0] rem_reg, rem_next;
    logic [PAT_W-1:0] dsr_reg, dsr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [PAT_W:0]   trial;
    logic             fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = (trial >= {1'b0, dsr_reg});

    // Shift one dividend bit into the remainder and subtract when it fits
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
            cnt_next  = CW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? PAT_W'(trial - {1'b0, dsr_reg}) : trial[PAT_W-1:0];
            quo_next = {quo_reg[DW-2:0], fits};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !start && dsr_reg != '0) |=> (rem_reg < dsr_reg))
        else $error("divider remainder not below divisor");
    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_reg != '0))
        else $error("divider busy with zero count");
`endif

endmodule

>>> rtl/dash_pattern_segmenter_unit.sv
// Top level: stroke dash pattern segmenter with shared serial divider and walk sequencer.
`timescale 1ns / 1ps
// One input word describes a contour; results are dash start/stop pairs along it.
// Input channel (in_valid/in_stall/in_word): a word is taken when valid is high and
// stall is low. Output channel (out_valid/out_stall/out_word): same rule; the final
// word caused by a contour carries last. A fill contour gives one not-applied word,
// a path over the dash limit gives one aborted word, a contour with no dash gives none.
// Per contour the serial divider first computes the dash estimate; the walk then
// steps over one pattern interval per cycle unless a dash waits for a free output
// slot, then rejoins the skipped first dash of a closed contour and flushes.
// One contour is processed at a time; in_stall stays high until its last word sits
// in the output register.
// A configuration write (cfg_we/cfg_index/cfg_data) renormalizes the phase with the
// same divider while in_stall is high. The same pass runs after reset, so input
// words are taken only once it finishes.
// A stalled receiver holds the output register and one pending word; the walk then
// waits until the output register frees.
module dash_pattern_segmenter_unit
    import dps_pkg::*;
#(
    parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
    parameter int FRAC_BITS     = FRAC_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_word_t           in_word,
    output logic               out_valid,
    input  logic               out_stall,
    output out_word_t          out_word,
    input  logic               cfg_we,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    localparam int DW    = LEN_W + 1 + FRAC_BITS;
    localparam int SW    = ((DW > EST_W) ? DW : EST_W) + 1;
    localparam int TOP_N = ((MAX_INTERVALS / 2) * 2 > 4) ? 4 :
                           (((MAX_INTERVALS / 2) * 2 < 2) ? 2 : (MAX_INTERVALS / 2) * 2);
    localparam logic [EST_W-1:0] EST_MAX = {EST_W{1'b1}};

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PSUM   = 4'd1;
    localparam logic [3:0] S_PMOD   = 4'd2;
    localparam logic [3:0] S_PWAIT  = 4'd3;
    localparam logic [3:0] S_LOCATE = 4'd4;
    localparam logic [3:0] S_EWAIT  = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_WALK   = 4'd7;
    localparam logic [3:0] S_CLOSE  = 4'd8;
    localparam logic [3:0] S_FLUSH  = 4'd9;
    localparam logic [3:0] S_SINGLE = 4'd10;

    // Configuration registers
    logic [2:0]         interval_count_reg;
    logic [31:0]        dash_phase_reg;
    logic [IVL_W-1:0]   iv_reg [4];
    logic [LIM_W-1:0]   dash_limit_reg;

    // Sequencer state
    logic [3:0]         state_reg, state_next;
    logic [PAT_W-1:0]   pattern_length_reg, pattern_length_next;
    logic [1:0]         first_index_reg, first_index_next;
    logic [IVL_W-1:0]   first_length_reg, first_length_next;
    logic [EST_W-1:0]   dash_estimate_reg, dash_estimate_next;
    logic [DIST_W-1:0]  walk_distance_reg, walk_distance_next;
    logic [1:0]         walk_index_reg, walk_index_next;
    logic [PAT_W-1:0]   ph_reg, ph_next;
    logic [1:0]         loc_reg, loc_next;
    logic [IVL_W-1:0]   dlen_reg, dlen_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               closed_reg, closed_next;
    logic               skip_reg, skip_next;
    logic               added_reg, added_next;
    logic [KCNT_W-1:0]  kcnt_reg, kcnt_next;
    logic [1:0]         status_reg, status_next;

    // Output register and one pending word
    logic               out_valid_reg, out_valid_next;
    out_word_t          out_reg, out_next;
    logic               pend_valid_reg, pend_valid_next;
    out_word_t          pend_reg, pend_next;

    // Shared divider
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic               div_done;
    logic [DW-1:0]      div_quo;
    logic [PAT_W-1:0]   div_rem;

    logic [2:0]         act_n;
    logic [1:0]         last_idx;
    logic [PAT_W-1:0]   pat_sum;
    logic               out_free;
    logic               slot_ok;
    logic               do_emit;
    out_word_t          new_res;
    logic [EST_W-1:0]   est_base;
    logic [SW-1:0]      est_sum;
    logic [IVL_W-1:0]   g;
    logic               on_w;
    logic [1:0]         idx_adv;
    logic [DIST_W-1:0]  stop_w;
    logic [31:0]        phase_mag;
    logic [DW-1:0]      est_num;
    logic [2:0]         cnt_even;

    dps_div #(.DW(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (pattern_length_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Active interval count: even, clamped to 2..TOP_N
    assign cnt_even = interval_count_reg & 3'd6;
    assign act_n    = (cnt_even < 3'd2) ? 3'd2 :
                      ((cnt_even > 3'(TOP_N)) ? 3'(TOP_N) : cnt_even);
    assign last_idx = 2'(act_n - 3'd1);

    assign pat_sum  = PAT_W'(iv_reg[0]) + PAT_W'(iv_reg[1]) +
                      ((act_n == 3'd4) ? (PAT_W'(iv_reg[2]) + PAT_W'(iv_reg[3])) : '0);

    assign phase_mag = dash_phase_reg[31] ? (~dash_phase_reg + 32'd1) : dash_phase_reg;
    assign est_num   = (act_n == 3'd4) ? (DW'(in_word.contour_length) << (FRAC_BITS + 1))
                                       : (DW'(in_word.contour_length) << FRAC_BITS);

    assign out_free = !out_valid_reg || !out_stall;
    assign slot_ok  = !pend_valid_reg || out_free;
    assign in_stall = (state_reg != S_IDLE) || cfg_we;
    assign g        = iv_reg[loc_reg];
    assign on_w     = !walk_index_reg[0] && !skip_reg;
    assign idx_adv  = (walk_index_reg == last_idx) ? 2'd0 : (walk_index_reg + 2'd1);
    assign stop_w   = walk_distance_reg + DIST_W'(dlen_reg);
    assign est_base = in_word.path_first ? '0 : dash_estimate_reg;
    assign est_sum  = SW'(dash_estimate_reg) + SW'(div_quo);

    always_comb
    begin
        state_next          = state_reg;
        pattern_length_next = pattern_length_reg;
        first_index_next    = first_index_reg;
        first_length_next   = first_length_reg;
        dash_estimate_next  = dash_estimate_reg;
        walk_distance_next  = walk_distance_reg;
        walk_index_next     = walk_index_reg;
        ph_next             = ph_reg;
        loc_next            = loc_reg;
        dlen_next           = dlen_reg;
        len_next            = len_reg;
        closed_next         = closed_reg;
        skip_next           = skip_reg;
        added_next          = added_reg;
        kcnt_next           = kcnt_reg;
        status_next         = status_reg;
        out_valid_next      = out_valid_reg;
        out_next            = out_reg;
        pend_valid_next     = pend_valid_reg;
        pend_next           = pend_reg;
        div_start           = 1'b0;
        div_dividend        = '0;
        do_emit             = 1'b0;
        new_res             = '0;

        // Drop the output word once taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !cfg_we)
                begin
                    len_next           = in_word.contour_length;
                    closed_next        = in_word.contour_closed;
                    dash_estimate_next = est_base;
                    if (!in_word.stroke)
                    begin
                        status_next = ST_FILL;
                        state_next  = S_SINGLE;
                    end
                    else if (pattern_length_reg == '0)
                    begin
                        dash_estimate_next = (in_word.contour_length != '0) ? EST_MAX
                                                                            : est_base;
                        state_next         = S_CHECK;
                    end
                    else
                    begin
                        div_start    = 1'b1;
                        div_dividend = est_num;
                        state_next   = S_EWAIT;
                    end
                end
            end
            S_PSUM:
            begin
                pattern_length_next = pat_sum;
                state_next          = S_PMOD;
            end
            S_PMOD:
            begin
                loc_next = 2'd0;
                if (pattern_length_reg == '0)
                begin
                    ph_next    = '0;
                    state_next = S_LOCATE;
                end
                else
                begin
                    div_start    = 1'b1;
                    div_dividend = DW'(phase_mag);
                    state_next   = S_PWAIT;
                end
            end
            S_PWAIT:
            begin
                if (div_done)
                begin
                    if (dash_phase_reg[31] && div_rem != '0)
                    begin
                        ph_next = pattern_length_reg - div_rem;
                    end
                    else
                    begin
                        ph_next = dash_phase_reg[31] ? '0 : div_rem;
                    end
                    state_next = S_LOCATE;
                end
            end
            S_LOCATE:
            begin
                // Step over one interval per cycle until the phase lands inside one
                if (ph_reg > PAT_W'(g) || (ph_reg == PAT_W'(g) && g != '0))
                begin
                    ph_next  = ph_reg - PAT_W'(g);
                    loc_next = loc_reg + 2'd1;
                    if (loc_reg == last_idx)
                    begin
                        first_index_next  = 2'd0;
                        first_length_next = (iv_reg[0] == '0) ? IVL_W'(1) : iv_reg[0];
                        state_next        = S_IDLE;
                    end
                end
                else
                begin
                    first_index_next  = loc_reg;
                    first_length_next = (PAT_W'(g) == ph_reg) ? IVL_W'(1)
                                                              : IVL_W'(PAT_W'(g) - ph_reg);
                    state_next        = S_IDLE;
                end
            end
            S_EWAIT:
            begin
                if (div_done)
                begin
                    dash_estimate_next = (est_sum > SW'(EST_MAX)) ? EST_MAX
                                                                  : est_sum[EST_W-1:0];
                    state_next         = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (dash_estimate_reg > (EST_W'(dash_limit_reg) << FRAC_BITS))
                begin
                    status_next = ST_ABORTED;
                    state_next  = S_SINGLE;
                end
                else
                begin
                    walk_distance_next = '0;
                    walk_index_next    = first_index_reg;
                    dlen_next          = first_length_reg;
                    skip_next          = closed_reg;
                    added_next         = 1'b0;
                    kcnt_next          = '0;
                    state_next         = S_WALK;
                end
            end
            S_WALK:
            begin
                if (DIST_W'(len_reg) > walk_distance_reg)
                begin
                    // Advance one interval unless a dash waits for a free slot
                    if (!(on_w && kcnt_reg < MAX_RESULTS && !slot_ok))
                    begin
                        if (on_w && kcnt_reg < MAX_RESULTS)
                        begin
                            do_emit            = 1'b1;
                            new_res.seg_start  = walk_distance_reg[LEN_W-1:0];
                            new_res.seg_stop   = (stop_w > DIST_W'(len_reg)) ? len_reg
                                                                             : stop_w[LEN_W-1:0];
                            new_res.move_first = 1'b1;
                            new_res.status     = ST_SEGMENT;
                            kcnt_next          = kcnt_reg + KCNT_W'(1);
                        end
                        walk_distance_next = stop_w;
                        skip_next          = 1'b0;
                        walk_index_next    = idx_adv;
                        dlen_next          = iv_reg[idx_adv];
                        added_next         = on_w;
                    end
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_CLOSE:
            begin
                // Rejoin the skipped first dash of a closed contour
                if (closed_reg && !first_index_reg[0] && kcnt_reg < MAX_RESULTS)
                begin
                    if (slot_ok)
                    begin
                        do_emit            = 1'b1;
                        new_res.seg_start  = '0;
                        new_res.seg_stop   = (LEN_W'(first_length_reg) > len_reg) ? len_reg
                                                                    : LEN_W'(first_length_reg);
                        new_res.move_first = !added_reg;
                        new_res.status     = ST_SEGMENT;
                        kcnt_next          = kcnt_reg + KCNT_W'(1);
                        state_next         = S_FLUSH;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_next        = '0;
                    out_next.status = status_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Hold the newest dash; push the older one out
        if (do_emit)
        begin
            if (pend_valid_reg)
            begin
                out_next       = pend_reg;
                out_valid_next = 1'b1;
            end
            pend_next       = new_res;
            pend_valid_next = 1'b1;
        end

        // Any register write renormalizes the phase
        if (cfg_we && cfg_index <= REG_DASH_LIMIT)
        begin
            state_next = S_PSUM;
        end
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_count_reg <= 3'd2;
            dash_phase_reg     <= '0;
            iv_reg[0]          <= IVL_W'(256);
            iv_reg[1]          <= IVL_W'(256);
            iv_reg[2]          <= '0;
            iv_reg[3]          <= '0;
            dash_limit_reg     <= LIM_W'(62);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_INTERVAL_COUNT: interval_count_reg <= cfg_data[2:0];
                REG_DASH_PHASE:     dash_phase_reg     <= cfg_data;
                REG_INTERVAL_A:     iv_reg[0]          <= cfg_data[IVL_W-1:0];
                REG_INTERVAL_B:     iv_reg[1]          <= cfg_data[IVL_W-1:0];
                REG_INTERVAL_C:     iv_reg[2]          <= cfg_data[IVL_W-1:0];
                REG_INTERVAL_D:     iv_reg[3]          <= cfg_data[IVL_W-1:0];
                REG_DASH_LIMIT:     dash_limit_reg     <= cfg_data[LIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_PSUM;
            pattern_length_reg <= '0;
            first_index_reg    <= '0;
            first_length_reg   <= '0;
            dash_estimate_reg  <= '0;
            walk_distance_reg  <= '0;
            walk_index_reg     <= '0;
            out_valid_reg      <= 1'b0;
            pend_valid_reg     <= 1'b0;
            kcnt_reg           <= '0;
            loc_reg            <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            pattern_length_reg <= pattern_length_next;
            first_index_reg    <= first_index_next;
            first_length_reg   <= first_length_next;
            dash_estimate_reg  <= dash_estimate_next;
            walk_distance_reg  <= walk_distance_next;
            walk_index_reg     <= walk_index_next;
            out_valid_reg      <= out_valid_next;
            pend_valid_reg     <= pend_valid_next;
            kcnt_reg           <= kcnt_next;
            loc_reg            <= loc_next;
        end
    end

    // Payload and work registers
    always_ff @(posedge clk)
    begin
        ph_reg     <= ph_next;
        dlen_reg   <= dlen_next;
        len_reg    <= len_next;
        closed_reg <= closed_next;
        skip_reg   <= skip_next;
        added_reg  <= added_next;
        status_reg <= status_next;
        out_reg    <= out_next;
        pend_reg   <= pend_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_reg;

`ifndef SYNTHESIS
    a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("pending word left behind after contour finished");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        kcnt_reg <= MAX_RESULTS)
        else $error("dash count beyond result limit");
    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg != S_IDLE))
        else $error("accepted word did not start processing");
    a_first_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |-> (first_length_reg != '0))
        else $error("walk started with zero first length");
`endif

endmodule
